[design/spq_pkg.sv]
`default_nettype none

package spq_pkg;

   // Default sizing of the slot store.
   localparam int DEFAULT_QUEUE_DEPTH = 64;
   localparam int DEFAULT_HANDLE_BITS = 16;

   // Fixed field widths of the request and response.
   localparam int IN_HANDLE_BITS  = 16;
   localparam int OUT_HANDLE_BITS = 16;
   localparam int PRIO_BITS       = 8;
   localparam int ORDER_BITS      = 32;
   localparam int STATUS_BITS     = 2;
   localparam int REQ_TDATA_BITS  = 24;
   localparam int RSP_TDATA_BITS  = 24;

   // Request kinds carried in tuser.
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Response status codes.
   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd3;

   // Ordering key of one slot: priority first, then arrival ticket.
   typedef struct packed {
      logic signed [PRIO_BITS-1:0] prio;
      logic [ORDER_BITS-1:0]       order;
   } rank_key_type;

endpackage

`default_nettype wire

[design/spq_slot_mem.sv]
`default_nettype none

module spq_slot_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 57
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[design/spq_rank.sv]
`default_nettype none

module spq_rank
   import spq_pkg::*;
(
   input  wire rank_key_type cand_key,
   input  wire rank_key_type best_key,
   output logic              cand_better
);

   logic [ORDER_BITS-1:0] order_diff;

   // Tickets wrap, so age is decided by the sign of the difference.
   assign order_diff = cand_key.order - best_key.order;

   always_comb begin
      if (cand_key.prio != best_key.prio) begin
         cand_better = (cand_key.prio > best_key.prio);
      end else begin
         cand_better = order_diff[ORDER_BITS-1];
      end
   end

endmodule

`default_nettype wire

[design/stable_priority_packet_queue_core.sv]
// Stable priority packet queue. Each request is a push of a packet handle with a signed
// priority or a pop of the highest-priority, oldest handle; each request gives exactly one
// response with a status, the popped handle and an empty flag. All slots live in one
// single-port-read memory that a small sequencer walks one slot per cycle, with one shared
// rank comparator judging the slot just read against the best so far. A pop scans every slot,
// a push stops at the lowest free slot, and a rejected request (null handle, full store,
// closed or empty pop) skips the scan and goes straight to the response. The request side is
// not ready while a request is in work. After reset the block runs a clearing pass over every
// memory slot before it takes its first request; writes to the open/close register are taken
// at any time.
`default_nettype none

module stable_priority_packet_queue_core
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   parameter int HANDLE_BITS = DEFAULT_HANDLE_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Request channel.
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // [15:0] packet_handle, [23:16] priority_req
   input  wire logic [REQ_TDATA_BITS-1:0] req_tdata,
   // [0] operation
   input  wire logic [0:0]                req_tuser,
   // Response channel.
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // [1:0] status, [17:2] popped_handle, [18] now_empty, [23:19] zero
   output logic [RSP_TDATA_BITS-1:0]      rsp_tdata,
   // Open/close register write channel.
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic                      csr_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = 1 + PRIO_BITS + ORDER_BITS + HANDLE_BITS;

   // Sequencer states.
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic rd_pend_ff, rd_pend_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic op_ff, op_in;
   logic [HANDLE_BITS-1:0] hdl_ff, hdl_in;
   logic signed [PRIO_BITS-1:0] prio_ff, prio_in;
   logic have_best_ff, have_best_in;
   rank_key_type best_key_ff, best_key_in;
   logic [AW-1:0] best_idx_ff, best_idx_in;
   logic [HANDLE_BITS-1:0] best_hdl_ff, best_hdl_in;
   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;
   logic [HANDLE_BITS-1:0] res_hdl_ff, res_hdl_in;
   logic [CW-1:0] count_ff, count_in;
   logic [ORDER_BITS-1:0] ticket_ff, ticket_in;
   logic open_ff, open_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [OUT_HANDLE_BITS-1:0] rsp_hdl_ff, rsp_hdl_in;
   logic rsp_empty_ff, rsp_empty_in;

   // Memory port signals.
   logic mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [EW-1:0] mem_wr_data;
   logic mem_rd_en;
   logic [EW-1:0] mem_rd_data;

   // Fields of the slot just read: valid, priority, ticket, handle from the top bit down.
   logic rd_valid;
   rank_key_type rd_key;
   logic [HANDLE_BITS-1:0] rd_hdl;
   logic cand_better;

   // Request fields.
   logic [IN_HANDLE_BITS-1:0] req_handle;
   logic signed [PRIO_BITS-1:0] req_prio;
   logic [HANDLE_BITS-1:0] push_handle;
   logic [OUT_HANDLE_BITS-1:0] res_hdl_out;

   assign req_handle = req_tdata[IN_HANDLE_BITS-1:0];
   assign req_prio   = req_tdata[IN_HANDLE_BITS +: PRIO_BITS];

   // The handle is kept at HANDLE_BITS and reported at the fixed 16-bit width.
   if (HANDLE_BITS >= IN_HANDLE_BITS) begin : g_hdl_wide
      assign push_handle = HANDLE_BITS'(req_handle);
      assign res_hdl_out = res_hdl_ff[OUT_HANDLE_BITS-1:0];
   end else begin : g_hdl_narrow
      assign push_handle = req_handle[HANDLE_BITS-1:0];
      assign res_hdl_out = OUT_HANDLE_BITS'(res_hdl_ff);
   end

   assign rd_valid     = mem_rd_data[EW-1];
   assign rd_key.prio  = mem_rd_data[EW-2 -: PRIO_BITS];
   assign rd_key.order = mem_rd_data[HANDLE_BITS +: ORDER_BITS];
   assign rd_hdl       = mem_rd_data[HANDLE_BITS-1:0];

   spq_slot_mem #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (EW)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (mem_rd_data)
   );

   spq_rank u_rank (
      .cand_key    (rd_key),
      .best_key    (best_key_ff),
      .cand_better (cand_better)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_pend_in    = rd_pend_ff;
      rd_idx_in     = rd_idx_ff;
      op_in         = op_ff;
      hdl_in        = hdl_ff;
      prio_in       = prio_ff;
      have_best_in  = have_best_ff;
      best_key_in   = best_key_ff;
      best_idx_in   = best_idx_ff;
      best_hdl_in   = best_hdl_ff;
      res_status_in = res_status_ff;
      res_hdl_in    = res_hdl_ff;
      count_in      = count_ff;
      ticket_in     = ticket_ff;
      open_in       = open_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_hdl_in    = rsp_hdl_ff;
      rsp_empty_in  = rsp_empty_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = cnt_ff[AW-1:0];
      mem_wr_data   = '0;
      mem_rd_en     = 1'b0;

      if (csr_valid) begin
         open_in = csr_data;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            // Write every slot empty, one per cycle.
            mem_wr_en = 1'b1;
            if (cnt_ff == (AW + 1)'(QUEUE_DEPTH - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + (AW + 1)'(1);
            end
         end

         ST_IDLE: begin
            if (req_tvalid) begin
               op_in        = req_tuser[0];
               hdl_in       = push_handle;
               prio_in      = req_prio;
               res_hdl_in   = '0;
               cnt_in       = '0;
               rd_pend_in   = 1'b0;
               have_best_in = 1'b0;
               if (req_tuser[0] == OP_PUSH) begin
                  if (push_handle == '0) begin
                     res_status_in = STATUS_NULL;
                     state_in      = ST_DONE;
                  end else if (count_ff >= CW'(QUEUE_DEPTH)) begin
                     res_status_in = STATUS_FULL;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  if (!open_ff || count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end

         ST_SCAN: begin
            // Issue one slot read per cycle; its data returns from the registered read port in the next cycle.
            mem_rd_en  = (cnt_ff < (AW + 1)'(QUEUE_DEPTH));
            rd_pend_in = mem_rd_en;
            rd_idx_in  = cnt_ff[AW-1:0];
            if (mem_rd_en) begin
               cnt_in = cnt_ff + (AW + 1)'(1);
            end

            if (op_ff == OP_PUSH) begin
               // The first empty slot met takes the new entry.
               if (rd_pend_ff && !rd_valid) begin
                  mem_wr_en     = 1'b1;
                  mem_wr_addr   = rd_idx_ff;
                  mem_wr_data   = {1'b1, prio_ff, ticket_ff, hdl_ff};
                  ticket_in     = ticket_ff + ORDER_BITS'(1);
                  count_in      = count_ff + CW'(1);
                  res_status_in = STATUS_OK;
                  rd_pend_in    = 1'b0;
                  state_in      = ST_DONE;
               end
            end else begin
               // Only a strictly better slot replaces the best so far.
               if (rd_pend_ff && rd_valid && (!have_best_ff || cand_better)) begin
                  have_best_in = 1'b1;
                  best_key_in  = rd_key;
                  best_idx_in  = rd_idx_ff;
                  best_hdl_in  = rd_hdl;
               end
               if (!rd_pend_ff && cnt_ff == (AW + 1)'(QUEUE_DEPTH)) begin
                  mem_wr_en     = 1'b1;
                  mem_wr_addr   = best_idx_ff;
                  mem_wr_data   = '0;
                  count_in      = count_ff - CW'(1);
                  res_status_in = STATUS_OK;
                  res_hdl_in    = best_hdl_ff;
                  state_in      = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            // Hand the result to the response register once it is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_hdl_in    = res_hdl_out;
               rsp_empty_in  = (count_ff == '0);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         have_best_ff <= 1'b0;
         count_ff     <= '0;
         ticket_ff    <= '0;
         open_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_pend_ff   <= rd_pend_in;
         have_best_ff <= have_best_in;
         count_ff     <= count_in;
         ticket_ff    <= ticket_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      op_ff         <= op_in;
      hdl_ff        <= hdl_in;
      prio_ff       <= prio_in;
      best_key_ff   <= best_key_in;
      best_idx_ff   <= best_idx_in;
      best_hdl_ff   <= best_hdl_in;
      res_status_ff <= res_status_in;
      res_hdl_ff    <= res_hdl_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hdl_ff    <= rsp_hdl_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_BITS - STATUS_BITS - OUT_HANDLE_BITS - 1)'(0),
                        rsp_empty_ff, rsp_hdl_ff, rsp_status_ff};

endmodule

`default_nettype wire

[design/spq_checker.sv]
`default_nettype none

module spq_checker
   import spq_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tvalid,
   input wire logic                      req_tready,
   input wire logic [REQ_TDATA_BITS-1:0] req_tdata,
   input wire logic [0:0]                req_tuser,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input wire logic                      csr_valid,
   input wire logic                      csr_ready,
   input wire logic                      csr_data
);

   // No response survives a reset.
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A request is worked on alone, so the block is busy right after taking one.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in work");

   // Only a successful pop hands back a handle.
   a_handle_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != STATUS_OK) |-> (rsp_tdata[17:2] == '0))
      else $error("handle reported with a failure status");

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind stable_priority_packet_queue_core spq_checker u_spq_checker (.*);

`default_nettype wire
